// ===== hdl/hssi_pkg.sv =====
// hssi_pkg: request/response structs, controller state, command and status
// types shared by the slot/species index core. No dependencies.
package hssi_pkg;

   localparam int HASH_W    = 64;
   localparam int SPEC_W    = 5;
   localparam int SIZE_W    = 6;
   localparam int CNT_W     = 13;   // slot_count register width
   localparam int DIV_CNT_W = 6;    // counts HASH_W restoring-division steps

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_QUERY  = 1'b1;

   typedef struct packed {
      logic              op;
      logic [SPEC_W-1:0] species;
      logic [HASH_W-1:0] hash;
   } req_type;

   typedef struct packed {
      logic              found;
      logic [SPEC_W-1:0] species_out;
      logic [SIZE_W-1:0] slot_size;
      logic              last;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DIV,
      ST_READ,
      ST_LOAD,
      ST_SUM,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic load;       // capture request, reset remainder
      logic div_step;   // one restoring-division step
      logic mem_rd;     // read bitmap of computed slot
      logic mem_wr;     // write back bitmap with species set
      logic bits_load;  // latch bitmap and per-byte counts
      logic sum;        // add byte counts into slot size
      logic emit;       // drive one response
      logic clr_wr;     // clear one slot after reset
   } cmd_type;

   typedef struct packed {
      logic is_query;
      logic bits_zero;
      logic last_one;
      logic clear_done;
   } sts_type;

endpackage

// ===== hdl/hash_slot_species_index_core.sv =====
// hash_slot_species_index_core: top level, slot_count register and APB port,
// hssi_ctrl sequencer and hssi_dpath datapath. Depends on hssi_pkg.
//
//  channel   ports                         flow
//  request   start, busy, req_data         in when start && !busy
//  response  rsp_valid, rsp_data           out, strobed by rsp_valid
//  config    psel..pready, paddr, pwdata   APB write/read, slot_count at 0x0
//
// A new request is accepted only once the previous one has finished (busy low).
// Each request runs a 64-step restoring division of the hash by the effective slot_count.
// After reset a clearing pass writes all SLOTS entries, busy high.
// Responses are strobed by rsp_valid and cannot be stalled by the receiver.
module hash_slot_species_index_core
   import hssi_pkg::*;
#(
   parameter int SLOTS       = 4096,
   parameter int MAX_SPECIES = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  req_type     req_data,
   output logic        rsp_valid,
   output rsp_type     rsp_data,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam logic REG_SLOT_COUNT = 1'b0;

   logic [CNT_W-1:0] slot_count_ff;
   cmd_type          cmd;
   sts_type          sts;

   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset)
         slot_count_ff <= CNT_W'(4096);
      else if (psel && penable && pwrite && (paddr[2] == REG_SLOT_COUNT))
         slot_count_ff <= pwdata[CNT_W-1:0];
   end

   assign prdata = (paddr[2] == REG_SLOT_COUNT) ? 32'(slot_count_ff) : '0;

   hssi_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .sts   (sts),
      .cmd   (cmd)
   );

   hssi_dpath #(
      .SLOTS       (SLOTS),
      .MAX_SPECIES (MAX_SPECIES)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_data   (req_data),
      .slot_count (slot_count_ff),
      .rsp_valid  (rsp_valid),
      .rsp_data   (rsp_data)
   );

endmodule

// ===== hdl/hssi_ctrl.sv =====
// hssi_ctrl: sequencer for the index core; drives datapath commands.
// Depends on hssi_pkg.
module hssi_ctrl
   import hssi_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type             state_ff, state_in;
   logic [DIV_CNT_W-1:0]  cnt_ff, cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clr_wr = 1'b1;
            if (sts.clear_done) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               cnt_in   = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == DIV_CNT_W'(HASH_W - 1)) state_in = ST_READ;
         end
         ST_READ: begin
            cmd.mem_rd = 1'b1;
            state_in   = ST_LOAD;
         end
         ST_LOAD: begin
            if (sts.is_query) begin
               cmd.bits_load = 1'b1;
               state_in      = ST_SUM;
            end else begin
               cmd.mem_wr = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         ST_SUM: begin
            cmd.sum  = 1'b1;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            cmd.emit = 1'b1;
            if (sts.bits_zero || sts.last_one) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

`ifndef SYNTHESIS
   a_load_enters_div: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> (state_ff == ST_DIV) && (cnt_ff == '0))
      else $error("load did not start division");
   a_div_length: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) && (cnt_ff == DIV_CNT_W'(HASH_W - 1)) |=> state_ff == ST_READ)
      else $error("division did not end after full width");
   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0(cmd))
      else $error("more than one datapath command");
`endif

endmodule

// ===== hdl/hssi_dpath.sv =====
// hssi_dpath: hash-mod-slot divider, slot bitmap memory with clear pass,
// and species emitter. Depends on hssi_pkg; commanded by hssi_ctrl.
module hssi_dpath
   import hssi_pkg::*;
#(
   parameter int SLOTS       = 4096,
   parameter int MAX_SPECIES = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  cmd_type          cmd,
   output sts_type          sts,
   input  req_type          req_data,
   input  logic [CNT_W-1:0] slot_count,
   output logic             rsp_valid,
   output rsp_type          rsp_data
);

   localparam int BW   = (MAX_SPECIES < 32) ? MAX_SPECIES : 32;
   localparam int NG   = (BW + 7) / 8;
   localparam int AW   = $clog2(SLOTS);
   localparam logic [20:0] SlotsW = 21'(SLOTS);

   logic [BW-1:0]     mem [SLOTS];

   logic [HASH_W-1:0] hash_ff;
   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic [CNT_W-1:0]  div_ff, div_in;
   logic              op_ff;
   logic [SPEC_W-1:0] species_ff;
   logic [BW-1:0]     rdata_ff;
   logic [BW-1:0]     bits_ff, bits_rest, set_mask;
   logic [3:0]        gcnt_ff [NG];
   logic [3:0]        gcnt_in [NG];
   logic [SIZE_W-1:0] size_ff, size_in;
   logic [AW-1:0]     clr_addr_ff;
   logic [AW-1:0]     slot, wr_addr;
   logic [BW-1:0]     wr_data;
   logic [CNT_W:0]    trial;
   logic [SPEC_W-1:0] low_idx;
   logic [NG*8-1:0]   rd_pad;
   logic              rsp_valid_ff;
   rsp_type           rsp_ff;

   // effective divisor: zero reads as one, clamp to SLOTS
   always_comb begin
      if (slot_count == '0)
         div_in = CNT_W'(1);
      else if ({8'b0, slot_count} > SlotsW)
         div_in = SlotsW[CNT_W-1:0];
      else
         div_in = slot_count;
   end

   // restoring division, one quotient bit per step; remainder stays below divisor
   assign trial  = {rem_ff, hash_ff[HASH_W-1]};
   assign rem_in = (trial >= {1'b0, div_ff}) ? CNT_W'(trial - {1'b0, div_ff})
                                              : trial[CNT_W-1:0];
   assign slot   = AW'(rem_ff);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         hash_ff    <= req_data.hash;
         rem_ff     <= '0;
         div_ff     <= div_in;
         op_ff      <= req_data.op;
         species_ff <= req_data.species;
      end else if (cmd.div_step) begin
         hash_ff <= {hash_ff[HASH_W-2:0], 1'b0};
         rem_ff  <= rem_in;
      end
   end

   always_comb begin
      for (int i = 0; i < BW; i++)
         set_mask[i] = (species_ff == SPEC_W'(i));
   end

   assign wr_addr = cmd.clr_wr ? clr_addr_ff : slot;
   assign wr_data = cmd.clr_wr ? '0 : (rdata_ff | set_mask);

   always_ff @(posedge clock) begin
      if (cmd.clr_wr || cmd.mem_wr) mem[wr_addr] <= wr_data;
      if (cmd.mem_rd) rdata_ff <= mem[slot];
   end

   always_ff @(posedge clock) begin
      if (reset)           clr_addr_ff <= '0;
      else if (cmd.clr_wr) clr_addr_ff <= clr_addr_ff + 1'b1;
   end

   // per-byte population counts, summed in the next cycle
   assign rd_pad = (NG*8)'(rdata_ff);
   always_comb begin
      for (int g = 0; g < NG; g++) begin
         gcnt_in[g] = '0;
         for (int j = 0; j < 8; j++)
            gcnt_in[g] = gcnt_in[g] + 4'(rd_pad[g*8+j]);
      end
      size_in = '0;
      for (int g = 0; g < NG; g++)
         size_in = size_in + SIZE_W'(gcnt_ff[g]);
   end

   always_comb begin
      low_idx = '0;
      for (int i = BW - 1; i >= 0; i--)
         if (bits_ff[i]) low_idx = SPEC_W'(i);
   end
   assign bits_rest = bits_ff & (bits_ff - 1'b1);

   always_ff @(posedge clock) begin
      if (cmd.bits_load) begin
         bits_ff <= rdata_ff;
         gcnt_ff <= gcnt_in;
      end else if (cmd.emit) begin
         bits_ff <= bits_rest;
      end
      if (cmd.sum) size_ff <= size_in;
      if (cmd.emit) begin
         rsp_ff.found       <= (bits_ff != '0);
         rsp_ff.species_out <= (bits_ff != '0) ? low_idx : '0;
         rsp_ff.slot_size   <= (bits_ff != '0) ? size_ff : '0;
         rsp_ff.last        <= (bits_ff == '0) || (bits_rest == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= cmd.emit;
   end

   assign sts.is_query   = (op_ff == OP_QUERY);
   assign sts.bits_zero  = (bits_ff == '0);
   assign sts.last_one   = (bits_rest == '0);
   assign sts.clear_done = (clr_addr_ff == AW'(SLOTS - 1));
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_data       = rsp_ff;

`ifndef SYNTHESIS
   a_rem_below_div: assert property (@(posedge clock) disable iff (reset)
      $past(cmd.div_step) |-> rem_ff < div_ff)
      else $error("remainder not below divisor");
   a_empty_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.found |-> rsp_ff.last && (rsp_ff.slot_size == '0))
      else $error("not-found response malformed");
   a_found_size: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.found |-> rsp_ff.slot_size != '0)
      else $error("found response with zero slot size");
`endif

endmodule
